// ===== design/dalu_pkg.sv =====
`default_nettype none

package dalu_pkg;

    // Operation codes carried in the command field.
    typedef enum logic [3:0] {
        OP_ADDS = 4'd0,
        OP_SUBS = 4'd1,
        OP_ADD  = 4'd2,
        OP_SUB  = 4'd3,
        OP_CMP  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_XOR  = 4'd7,
        OP_ABS  = 4'd8,
        OP_MOV  = 4'd9,
        OP_SHL2 = 4'd10,
        OP_SHL8 = 4'd11,
        OP_SHLM = 4'd12,
        OP_RSUB = 4'd13,
        OP_ASR1 = 4'd14,
        OP_END  = 4'd15
    } op_t;

    localparam int unsigned DATA_W = 24;
    localparam int unsigned FLAG_W = 5;

    // Flag bit positions.
    localparam int unsigned FLAG_N  = 4;
    localparam int unsigned FLAG_C  = 3;
    localparam int unsigned FLAG_V  = 2;
    localparam int unsigned FLAG_LT = 1;
    localparam int unsigned FLAG_Z  = 0;

    localparam logic [DATA_W-1:0] MAX_POS = 24'h7fffff;
    localparam logic [DATA_W-1:0] MAX_NEG = 24'h800000;

    // Operands after decode: the adder inputs are already chosen.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [FLAG_W-1:0] flags;
    } dec_t;

    // Raw result before saturation of the clamping adds.
    typedef struct packed {
        logic              clamp;
        logic              a_sign;
        logic [DATA_W-1:0] value;
        logic [FLAG_W-1:0] flags;
    } raw_t;

    // Final result.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [FLAG_W-1:0] flags;
    } res_t;

endpackage

`default_nettype wire

// ===== design/dsp_alu_24bit_flags_unit.sv =====
// 24-bit DSP ALU with condition flags.
//
// Input channel s_axis_*: one request per operation, carrying the opcode,
// two 24-bit operands and the five incoming flags (N, C, V, LT, Z).
// Output channel m_axis_*: one request per operation, carrying the 24-bit
// result and the updated flags.
//
// Throughput is one operation per cycle while the receiver keeps
// m_axis_tready high. The three register stages are decode with operand
// negation, the 25-bit add with the logic and shift units, and saturation
// into the output register.
//
// Reset clears the valid bits of all stages; no result is pending after it.
// When the receiver holds m_axis_tready low, the output register keeps its
// request and the stages behind it fill up one by one before s_axis_tready
// falls, so nothing is lost or repeated.
`default_nettype none

module dsp_alu_24bit_flags_unit
    import dalu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[3:0], operand_a[27:4], operand_b[51:28], flags_in[56:52], zeros above
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_value[23:0], flags_out[28:24], zeros above
    output logic [31:0]      m_axis_tdata
);

    logic adv1;
    logic adv2;
    logic adv3;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    dec_t dec_reg;
    dec_t dec_next;
    raw_t raw_reg;
    raw_t raw_next;
    res_t res_reg;
    res_t res_next;

    // Stage advance: a stage moves on when it is empty or its successor moves.
    assign adv3          = !v3_reg || m_axis_tready;
    assign adv2          = !v2_reg || adv3;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    // Stage 1: unpack the request and choose the adder inputs.
    always_comb
    begin
        logic [DATA_W-1:0] b_in;
        logic [DATA_W-1:0] b_neg;
        b_in           = s_axis_tdata[51:28];
        b_neg          = (~b_in) + 24'd1;
        dec_next.op    = op_t'(s_axis_tdata[3:0]);
        dec_next.a     = s_axis_tdata[27:4];
        dec_next.b     = b_in;
        dec_next.flags = s_axis_tdata[56:52];
        dec_next.x     = s_axis_tdata[27:4];
        dec_next.y     = b_in;
        case (dec_next.op)
            OP_SUBS, OP_SUB, OP_CMP:
            begin
                dec_next.y = b_neg;
            end
            OP_RSUB:
            begin
                dec_next.x = MAX_POS;
                dec_next.y = b_neg;
            end
            default:
            begin
                dec_next.y = b_in;
            end
        endcase
    end

    // Stage 2: adder, logic operations and shifts.
    always_comb
    begin
        logic [DATA_W:0]   sum;
        logic              sum_sign;
        logic              ovf;
        logic [FLAG_W-1:0] sum_flags;
        logic [FLAG_W-1:0] f;
        logic [DATA_W-1:0] r;
        logic              b_sign;
        logic              shl_ovf;

        sum      = {1'b0, dec_reg.x} + {1'b0, dec_reg.y};
        sum_sign = sum[DATA_W-1];
        ovf      = (dec_reg.x[DATA_W-1] == dec_reg.y[DATA_W-1]) &&
                   (dec_reg.x[DATA_W-1] != sum_sign);
        b_sign   = dec_reg.b[DATA_W-1];

        sum_flags          = dec_reg.flags;
        sum_flags[FLAG_C]  = sum[DATA_W];
        sum_flags[FLAG_N]  = sum_sign;
        sum_flags[FLAG_Z]  = (sum[DATA_W-1:0] == '0);
        sum_flags[FLAG_V]  = ovf;
        sum_flags[FLAG_LT] = ovf ? !sum_sign : sum_sign;

        f       = dec_reg.flags;
        r       = '0;
        shl_ovf = 1'b0;

        case (dec_reg.op)
            OP_ADDS, OP_SUBS, OP_ADD, OP_SUB, OP_RSUB:
            begin
                r = sum[DATA_W-1:0];
                f = sum_flags;
            end
            OP_CMP:
            begin
                r = dec_reg.a;
                f = sum_flags;
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                if (dec_reg.op == OP_AND)
                begin
                    r = dec_reg.a & dec_reg.b;
                end
                else if (dec_reg.op == OP_OR)
                begin
                    r = dec_reg.a | dec_reg.b;
                end
                else
                begin
                    r = dec_reg.a ^ dec_reg.b;
                end
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_ABS:
            begin
                r         = b_sign ? ~dec_reg.b : dec_reg.b;
                f[FLAG_N] = 1'b0;
                f[FLAG_C] = b_sign;
                f[FLAG_Z] = (r == '0);
            end
            OP_MOV:
            begin
                r = dec_reg.b;
            end
            OP_SHL2, OP_SHL8:
            begin
                // The shift fits only when the bits shifted out match the sign.
                if (dec_reg.op == OP_SHL2)
                begin
                    shl_ovf   = (dec_reg.b[23:21] != 3'b000) &&
                                (dec_reg.b[23:21] != 3'b111);
                    r         = {dec_reg.b[21:0], 2'b00};
                    f[FLAG_C] = dec_reg.b[22];
                end
                else
                begin
                    shl_ovf   = (dec_reg.b[23:15] != 9'h000) &&
                                (dec_reg.b[23:15] != 9'h1ff);
                    r         = {dec_reg.b[15:0], 8'h00};
                    f[FLAG_C] = dec_reg.b[16];
                end
                if (shl_ovf)
                begin
                    r = b_sign ? MAX_NEG : MAX_POS;
                end
                f[FLAG_V] = shl_ovf;
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_SHLM:
            begin
                r         = {1'b0, dec_reg.b[7:0], 15'd0};
                f[FLAG_N] = 1'b0;
                f[FLAG_C] = b_sign;
            end
            OP_ASR1:
            begin
                r         = {b_sign, dec_reg.b[DATA_W-1:1]};
                f[FLAG_N] = b_sign;
                f[FLAG_C] = dec_reg.b[0];
            end
            default:
            begin
                r = '0;
            end
        endcase

        raw_next.clamp  = (dec_reg.op == OP_ADDS) || (dec_reg.op == OP_SUBS);
        raw_next.a_sign = dec_reg.a[DATA_W-1];
        raw_next.value  = r;
        raw_next.flags  = f;
    end

    // Stage 3: saturate the clamping adds on overflow.
    always_comb
    begin
        res_next.value = raw_reg.value;
        res_next.flags = raw_reg.flags;
        if (raw_reg.clamp && raw_reg.flags[FLAG_V])
        begin
            res_next.value         = raw_reg.a_sign ? MAX_NEG : MAX_POS;
            res_next.flags[FLAG_N] = raw_reg.a_sign;
            res_next.flags[FLAG_Z] = 1'b0;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers, loaded only when a stage takes a valid request.
    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            dec_reg <= dec_next;
        end
        if (adv2 && v1_reg)
        begin
            raw_reg <= raw_next;
        end
        if (adv3 && v2_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {3'b000, res_reg.flags, res_reg.value};

endmodule

`default_nettype wire

// ===== design/dalu_checker.sv =====
`default_nettype none

module dalu_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result request stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // With nothing waiting at the output the pipeline can always take a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // No result appears straight out of reset.
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result request present after reset");

    // The padding bits above the flags are always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:29] == 3'b000))
        else $error("non-zero padding in result");

endmodule

bind dsp_alu_24bit_flags_unit dalu_checker u_dalu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/dalu_result_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the ALU, works out the result of every accepted
// request and compares it with what comes out, in order.
module dalu_result_checker
    import dalu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // command[3:0], operand_a[27:4], operand_b[51:28], flags_in[56:52], zeros above
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_value[23:0], flags_out[28:24], zeros above
    input  wire logic [31:0] m_axis_tdata,
    output int               pending_count,
    output int               error_count
);

    // Results still owed by the block, oldest first.
    res_t awaited_results[$];
    int   mismatches = 0;

    function automatic logic [DATA_W-1:0] negate24(input logic [DATA_W-1:0] v);
        return ~v + 1'b1;
    endfunction

    // 24-bit add that updates all five flags; subtraction adds the negated operand.
    function automatic logic [DATA_W-1:0] add_with_flags(
        input logic [DATA_W-1:0] x,
        input logic [DATA_W-1:0] y,
        inout logic [FLAG_W-1:0] f
    );
        logic [DATA_W:0] sum;
        logic            ovf;
        sum = {1'b0, x} + {1'b0, y};
        ovf = (x[DATA_W-1] == y[DATA_W-1]) && (x[DATA_W-1] != sum[DATA_W-1]);
        f[FLAG_C]  = sum[DATA_W];
        f[FLAG_N]  = sum[DATA_W-1];
        f[FLAG_Z]  = (sum[DATA_W-1:0] == '0);
        f[FLAG_V]  = ovf;
        f[FLAG_LT] = sum[DATA_W-1] ^ ovf;
        return sum[DATA_W-1:0];
    endfunction

    // On overflow the sum clamps by the sign of operand a.
    function automatic logic [DATA_W-1:0] clamp_sum(
        input logic [DATA_W-1:0] sum,
        input logic              a_neg,
        inout logic [FLAG_W-1:0] f
    );
        if (!f[FLAG_V])
            return sum;
        f[FLAG_N] = a_neg;
        f[FLAG_Z] = 1'b0;
        return a_neg ? MAX_NEG : MAX_POS;
    endfunction

    // Left shift that saturates unless the top sh+1 bits are all equal.
    function automatic logic [DATA_W-1:0] shift_left_sat(
        input logic [DATA_W-1:0] v,
        input int unsigned       sh,
        inout logic [FLAG_W-1:0] f
    );
        logic [DATA_W-1:0] top_bits;
        logic [DATA_W-1:0] all_ones;
        logic [DATA_W-1:0] r;
        logic              ovf;
        top_bits = v >> (DATA_W - 1 - sh);
        all_ones = (24'd1 << (sh + 1)) - 1'b1;
        ovf      = (top_bits != '0) && (top_bits != all_ones);
        r        = ovf ? (v[DATA_W-1] ? MAX_NEG : MAX_POS) : (v << sh);
        f[FLAG_C] = v[DATA_W - sh];
        f[FLAG_V] = ovf;
        f[FLAG_N] = r[DATA_W-1];
        f[FLAG_Z] = (r == '0);
        return r;
    endfunction

    // Result and flags of one request.
    function automatic res_t compute_alu_result(input logic [63:0] req);
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [FLAG_W-1:0] f;
        res_t              res;
        op = op_t'(req[3:0]);
        a  = req[27:4];
        b  = req[51:28];
        f  = req[56:52];
        r  = '0;
        case (op)
            OP_ADDS:
            begin
                r = add_with_flags(a, b, f);
                r = clamp_sum(r, a[DATA_W-1], f);
            end
            OP_SUBS:
            begin
                r = add_with_flags(a, negate24(b), f);
                r = clamp_sum(r, a[DATA_W-1], f);
            end
            OP_ADD:  r = add_with_flags(a, b, f);
            OP_SUB:  r = add_with_flags(a, negate24(b), f);
            OP_CMP:
            begin
                void'(add_with_flags(a, negate24(b), f));
                r = a;
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                r = (op == OP_AND) ? (a & b) : (op == OP_OR) ? (a | b) : (a ^ b);
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_ABS:
            begin
                f[FLAG_N] = 1'b0;
                f[FLAG_C] = b[DATA_W-1];
                r = b[DATA_W-1] ? ~b : b;
                f[FLAG_Z] = (r == '0);
            end
            OP_MOV:  r = b;
            OP_SHL2: r = shift_left_sat(b, 2, f);
            OP_SHL8: r = shift_left_sat(b, 8, f);
            OP_SHLM:
            begin
                f[FLAG_N] = 1'b0;
                f[FLAG_C] = b[DATA_W-1];
                r = {1'b0, b[7:0], 15'd0};
            end
            OP_RSUB: r = add_with_flags(MAX_POS, negate24(b), f);
            OP_ASR1:
            begin
                f[FLAG_N] = b[DATA_W-1];
                f[FLAG_C] = b[0];
                r = {b[DATA_W-1], b[DATA_W-1:1]};
            end
            default: r = '0;
        endcase
        res.value = r;
        res.flags = f;
        return res;
    endfunction

    // Both channels are sampled on the clock edge; new requests are queued
    // before the outgoing result is matched.
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(compute_alu_result(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata[23:0];
                got.flags = m_axis_tdata[28:24];
                if (awaited_results.size() == 0)
                begin
                    $error("result_value: expected none, got 0x%06h", got.value);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("result_value: expected 0x%06h, got 0x%06h",
                               want.value, got.value);
                        mismatches++;
                    end
                    if (got.flags !== want.flags)
                    begin
                        $error("flags_out: expected 0x%02h, got 0x%02h",
                               want.flags, got.flags);
                        mismatches++;
                    end
                end
            end
        end
        pending_count <= awaited_results.size();
        error_count   <= mismatches;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import dalu_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;

    // Operand values at and next to the sign boundaries.
    localparam logic [DATA_W-1:0] CORNER_VALUES [6] = '{
        24'h000000, 24'h000001, 24'h7fffff, 24'h800000, 24'h800001, 24'hffffff
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    int          pending_count;
    int          error_count;
    int          burst_left    = 0;
    int          stall_mode    = 0;
    int          stall_phase   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dsp_alu_24bit_flags_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dalu_result_checker u_result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .pending_count (pending_count),
        .error_count   (error_count)
    );

    function automatic logic [63:0] pack_request(
        input op_t               op,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [FLAG_W-1:0] f
    );
        return {7'd0, f, b, a, op};
    endfunction

    // Operand mix: fully random, corners, small magnitudes of either sign and
    // sign-extended values of random width, so that shifts often fit.
    function automatic logic [DATA_W-1:0] rand_operand();
        logic        [DATA_W-1:0] raw;
        logic signed [DATA_W-1:0] ext;
        int unsigned              w;
        raw = DATA_W'($urandom);
        case ($urandom_range(0, 5))
            0: return raw;
            1: return CORNER_VALUES[$urandom_range(0, 5)];
            2: return DATA_W'($urandom_range(0, 255));
            3: return 24'd0 - DATA_W'($urandom_range(1, 256));
            default:
            begin
                w   = $urandom_range(1, 23);
                ext = raw << (DATA_W - w);
                return ext >>> (DATA_W - w);
            end
        endcase
    endfunction

    // Sends one request; bursts of random length are separated by random gaps.
    task automatic send_request(input logic [63:0] word);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // The receiver switches between stall patterns, holding each for a random time.
    always @(posedge clk)
    begin : rx_stall
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(16, 160);
        end
        stall_phase--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
            default: m_axis_tready <= ((stall_phase % 5) < 3);
        endcase
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Saturating add and subtract, including the most negative subtrahend.
        send_request(pack_request(OP_ADDS, 24'h7fffff, 24'h000001, 5'h00));
        send_request(pack_request(OP_ADDS, 24'h800000, 24'hffffff, 5'h1f));
        send_request(pack_request(OP_SUBS, 24'h800000, 24'h000001, 5'h00));
        send_request(pack_request(OP_SUBS, 24'h7fffff, 24'h800000, 5'h01));
        // Plain add, subtract and compare.
        send_request(pack_request(OP_ADD,  24'hffffff, 24'h000001, 5'h00));
        send_request(pack_request(OP_SUB,  24'h000000, 24'h800000, 5'h00));
        send_request(pack_request(OP_CMP,  24'h123456, 24'h123456, 5'h1f));
        // Logic operations.
        send_request(pack_request(OP_AND,  24'hffffff, 24'h800000, 5'h0e));
        send_request(pack_request(OP_OR,   24'h000000, 24'h000000, 5'h10));
        send_request(pack_request(OP_XOR,  24'haaaaaa, 24'h555555, 5'h00));
        // Absolute value of the most negative value, minus one and the maximum.
        send_request(pack_request(OP_ABS,  24'h000000, 24'h800000, 5'h10));
        send_request(pack_request(OP_ABS,  24'h000000, 24'hffffff, 5'h00));
        send_request(pack_request(OP_ABS,  24'hffffff, 24'h7fffff, 5'h1f));
        send_request(pack_request(OP_MOV,  24'hffffff, 24'h000000, 5'h1f));
        // Shifts that overflow and shifts that just fit.
        send_request(pack_request(OP_SHL2, 24'h000000, 24'h200000, 5'h00));
        send_request(pack_request(OP_SHL2, 24'h000000, 24'he00000, 5'h1f));
        send_request(pack_request(OP_SHL8, 24'h000000, 24'hff8000, 5'h00));
        send_request(pack_request(OP_SHL8, 24'h000000, 24'h008000, 5'h1f));
        send_request(pack_request(OP_SHL8, 24'h000000, 24'h000000, 5'h04));
        send_request(pack_request(OP_SHLM, 24'h000000, 24'hffffff, 5'h11));
        // Reverse subtract with the most negative subtrahend and with overflow.
        send_request(pack_request(OP_RSUB, 24'h000000, 24'h800000, 5'h00));
        send_request(pack_request(OP_RSUB, 24'h000000, 24'hffffff, 5'h00));
        send_request(pack_request(OP_ASR1, 24'h000000, 24'h800001, 5'h00));
        send_request(pack_request(OP_ASR1, 24'h000000, 24'h7fffff, 5'h1f));
        send_request(pack_request(OP_END,  24'hffffff, 24'hffffff, 5'h1f));
        wait_for_drain();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
                wait_for_drain();
            send_request(pack_request(op_t'($urandom_range(0, 15)), rand_operand(),
                                      rand_operand(), FLAG_W'($urandom_range(0, 31))));
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
